// ===== hdl/tgc_pkg.sv =====
package tgc_pkg;

  localparam int NUM_CHANNELS = 5;
  localparam int TIME_W       = 32;
  localparam int CHAN_W       = 3;
  localparam int NOW_W        = 32;
  localparam int SAMPLE_W     = 16;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 3;

  // register reset values
  localparam logic [CFG_W-1:0] RST_TOUCH_THRESHOLD = 16'd300;
  localparam logic [CFG_W-1:0] RST_RELEASE_MARGIN  = 16'd100;
  localparam logic [CFG_W-1:0] RST_DEBOUNCE_MS     = 16'd50;
  localparam logic [CFG_W-1:0] RST_CLICK_LIMIT_MS  = 16'd1500;
  localparam logic [CFG_W-1:0] RST_LONG_LIMIT_MS   = 16'd3000;
  localparam logic [CFG_W-1:0] RST_HOLD_MS         = 16'd3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOUCH_THRESHOLD = 3'd0,
    CFG_RELEASE_MARGIN  = 3'd1,
    CFG_DEBOUNCE_MS     = 3'd2,
    CFG_CLICK_LIMIT_MS  = 3'd3,
    CFG_LONG_LIMIT_MS   = 3'd4,
    CFG_HOLD_MS         = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_READ   = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic                kind;
    logic [CHAN_W-1:0]   channel;
    logic [NOW_W-1:0]    now_ms;
    logic [SAMPLE_W-1:0] sample;
  } tgc_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_channel;
    logic              touched;
    logic              held;
    logic              clicked;
    logic              long_clicked;
  } tgc_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] touch_threshold;
    logic [CFG_W-1:0] release_margin;
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] click_limit_ms;
    logic [CFG_W-1:0] long_limit_ms;
    logic [CFG_W-1:0] hold_ms;
  } tgc_cfg_t;

  // per-channel status bits
  typedef struct packed {
    logic pressed;
    logic hold;
    logic click_ev;
    logic long_ev;
  } tgc_flags_t;

endpackage

// ===== hdl/tgc_cfg_regs.sv =====
module tgc_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [15:0]              cfg_wdata_i,
  output tgc_pkg::tgc_cfg_t        cfg_o
);
  import tgc_pkg::*;

  tgc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TOUCH_THRESHOLD: cfg_d.touch_threshold = cfg_wdata_i;
        CFG_RELEASE_MARGIN:  cfg_d.release_margin  = cfg_wdata_i;
        CFG_DEBOUNCE_MS:     cfg_d.debounce_ms     = cfg_wdata_i;
        CFG_CLICK_LIMIT_MS:  cfg_d.click_limit_ms  = cfg_wdata_i;
        CFG_LONG_LIMIT_MS:   cfg_d.long_limit_ms   = cfg_wdata_i;
        CFG_HOLD_MS:         cfg_d.hold_ms         = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.touch_threshold <= RST_TOUCH_THRESHOLD;
      cfg_q.release_margin  <= RST_RELEASE_MARGIN;
      cfg_q.debounce_ms     <= RST_DEBOUNCE_MS;
      cfg_q.click_limit_ms  <= RST_CLICK_LIMIT_MS;
      cfg_q.long_limit_ms   <= RST_LONG_LIMIT_MS;
      cfg_q.hold_ms         <= RST_HOLD_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/tgc_update.sv =====
module tgc_update #(
  parameter int TIME_BITS = tgc_pkg::TIME_W
) (
  input  tgc_pkg::tgc_cfg_t       cfg_i,
  input  logic                    kind_i,
  input  logic [TIME_BITS-1:0]    now_i,
  input  logic [15:0]             sample_i,
  input  tgc_pkg::tgc_flags_t     flags_i,
  input  logic [TIME_BITS-1:0]    trans_time_i,
  input  logic [TIME_BITS-1:0]    press_time_i,
  input  logic [TIME_BITS-1:0]    click_time_i,
  input  logic [TIME_BITS-1:0]    long_time_i,
  output tgc_pkg::tgc_flags_t     flags_o,
  output tgc_pkg::tgc_flags_t     report_o,
  output logic [TIME_BITS-1:0]    trans_time_o,
  output logic [TIME_BITS-1:0]    press_time_o,
  output logic [TIME_BITS-1:0]    click_time_o,
  output logic [TIME_BITS-1:0]    long_time_o
);
  import tgc_pkg::*;

  logic [TIME_BITS-1:0] since;
  logic                 active;
  logic                 press_hit;
  logic                 release_hit;
  logic [CFG_W:0]       release_sum;
  tgc_flags_t           upd;
  logic [TIME_BITS-1:0] upd_click_time;
  logic [TIME_BITS-1:0] upd_long_time;
  logic [TIME_BITS-1:0] upd_press_time;
  logic [TIME_BITS-1:0] upd_trans_time;

  assign since       = now_i - trans_time_i;
  assign active      = since > TIME_BITS'(cfg_i.debounce_ms);
  assign release_sum = {1'b0, sample_i} + {1'b0, cfg_i.release_margin};
  assign press_hit   = (sample_i > cfg_i.touch_threshold) && !flags_i.pressed;
  assign release_hit = (release_sum < {1'b0, cfg_i.touch_threshold}) && flags_i.pressed;

  // sample update: edge detection, then expiry and hold checks on the new state
  always_comb begin
    upd            = flags_i;
    upd_trans_time = trans_time_i;
    upd_press_time = press_time_i;
    upd_click_time = click_time_i;
    upd_long_time  = long_time_i;
    if (active) begin
      if (press_hit) begin
        upd.pressed    = 1'b1;
        upd_trans_time = now_i;
        upd_press_time = now_i;
      end else if (release_hit) begin
        upd.pressed    = 1'b0;
        upd.hold       = 1'b0;
        upd_trans_time = now_i;
        if (since < TIME_BITS'(cfg_i.click_limit_ms)) begin
          upd.click_ev   = 1'b1;
          upd_click_time = now_i;
        end else if (since < TIME_BITS'(cfg_i.long_limit_ms)) begin
          upd.long_ev   = 1'b1;
          upd_long_time = now_i;
        end
      end
      if (upd.click_ev && ((now_i - upd_click_time) > TIME_BITS'(cfg_i.click_limit_ms))) begin
        upd.click_ev = 1'b0;
      end
      if (upd.long_ev && ((now_i - upd_long_time) > TIME_BITS'(cfg_i.long_limit_ms))) begin
        upd.long_ev = 1'b0;
      end
      if (upd.pressed && ((now_i - upd_press_time) > TIME_BITS'(cfg_i.hold_ms))) begin
        upd.hold = 1'b1;
      end
    end
  end

  always_comb begin
    flags_o      = upd;
    report_o     = upd;
    trans_time_o = upd_trans_time;
    press_time_o = upd_press_time;
    click_time_o = upd_click_time;
    long_time_o  = upd_long_time;
    if (item_kind_e'(kind_i) == KIND_READ) begin
      // read reports stored flags, then clears the events
      report_o          = flags_i;
      flags_o           = flags_i;
      flags_o.click_ev  = 1'b0;
      flags_o.long_ev   = 1'b0;
      trans_time_o      = trans_time_i;
      press_time_o      = press_time_i;
      click_time_o      = click_time_i;
      long_time_o       = long_time_i;
    end
  end

endmodule

// ===== hdl/touch_gesture_classifier.sv =====
// touch gesture classifier: per-pad press/release detection with hysteresis
// and debounce, click / long-click events with expiry, and a hold flag
// input channel: in_valid_i / in_ready_o carry one item per transfer, either
//   a sensor sample for a pad or a read that reports the pad and clears its
//   click and long-click events
// output channel: out_valid_o / out_ready_i carry exactly one status item per
//   input item, in input order
// config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at once;
//   write only while no item is in flight
// latency: an item transferred at one edge is processed from the input
//   register during the next cycle; its result is valid the cycle after that
// throughput: one item per cycle; the channel state update is one pass of
//   compares and subtracts on the selected pad, so back-to-back items on the
//   same pad see each other's effects
// stall: when out_ready_i is low the result register holds, the input register
//   fills, and in_ready_o drops; no item is lost or repeated
// reset: all pad state clears to released with no events, times at zero, and
//   registers return to their default values
module touch_gesture_classifier #(
  parameter int CHANNELS  = tgc_pkg::NUM_CHANNELS,
  parameter int TIME_BITS = tgc_pkg::TIME_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tgc_pkg::tgc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tgc_pkg::tgc_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i
);
  import tgc_pkg::*;

  // channel compare width: wide enough for the channel field and CHANNELS
  localparam int CH_CMP_W = ($clog2(CHANNELS + 1) > CHAN_W) ? $clog2(CHANNELS + 1) : CHAN_W;

  tgc_cfg_t cfg;

  // input register stage
  tgc_in_t  in_q;
  logic     in_valid_q;
  // result register stage
  tgc_out_t out_q, out_d;
  logic     out_valid_q;
  logic     advance;

  // per-pad state
  tgc_flags_t           flags_q      [CHANNELS];
  logic [TIME_BITS-1:0] trans_time_q [CHANNELS];
  logic [TIME_BITS-1:0] press_time_q [CHANNELS];
  logic [TIME_BITS-1:0] click_time_q [CHANNELS];
  logic [TIME_BITS-1:0] long_time_q  [CHANNELS];

  logic [CH_CMP_W-1:0]  chan_ext;
  logic                 in_range;
  logic [CHANNELS-1:0]  sel_hit;
  tgc_flags_t           sel_flags;
  logic [TIME_BITS-1:0] sel_trans, sel_press, sel_click, sel_long;
  logic [TIME_BITS-1:0] now_ext;

  tgc_flags_t           new_flags, report;
  logic [TIME_BITS-1:0] new_trans, new_press, new_click, new_long;

  tgc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // held item moves on when the result register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // pad select
  assign chan_ext = CH_CMP_W'(in_q.channel);
  assign in_range = chan_ext < CH_CMP_W'(CHANNELS);
  assign now_ext  = TIME_BITS'(in_q.now_ms);

  always_comb begin
    sel_hit   = '0;
    sel_flags = '0;
    sel_trans = '0;
    sel_press = '0;
    sel_click = '0;
    sel_long  = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (chan_ext == CH_CMP_W'(c)) begin
        sel_hit[c] = 1'b1;
        sel_flags  = flags_q[c];
        sel_trans  = trans_time_q[c];
        sel_press  = press_time_q[c];
        sel_click  = click_time_q[c];
        sel_long   = long_time_q[c];
      end
    end
  end

  tgc_update #(
    .TIME_BITS (TIME_BITS)
  ) u_update (
    .cfg_i        (cfg),
    .kind_i       (in_q.kind),
    .now_i        (now_ext),
    .sample_i     (in_q.sample),
    .flags_i      (sel_flags),
    .trans_time_i (sel_trans),
    .press_time_i (sel_press),
    .click_time_i (sel_click),
    .long_time_i  (sel_long),
    .flags_o      (new_flags),
    .report_o     (report),
    .trans_time_o (new_trans),
    .press_time_o (new_press),
    .click_time_o (new_click),
    .long_time_o  (new_long)
  );

  // state write-back on the same edge that loads the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        flags_q[c]      <= '0;
        trans_time_q[c] <= '0;
        press_time_q[c] <= '0;
        click_time_q[c] <= '0;
        long_time_q[c]  <= '0;
      end
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (advance && in_range && sel_hit[c]) begin
          flags_q[c]      <= new_flags;
          trans_time_q[c] <= new_trans;
          press_time_q[c] <= new_press;
          click_time_q[c] <= new_click;
          long_time_q[c]  <= new_long;
        end
      end
    end
  end

  // result: out-of-range pads report all flags low
  always_comb begin
    out_d.out_channel  = in_q.channel;
    out_d.touched      = in_range && report.pressed;
    out_d.held         = in_range && report.hold;
    out_d.clicked      = in_range && report.click_ev;
    out_d.long_clicked = in_range && report.long_ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/tgc_checker.sv =====
module tgc_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  tgc_pkg::tgc_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  tgc_pkg::tgc_out_t out_data_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  output int                errors_o,
  output int                in_flight_o
);
  import tgc_pkg::*;

  logic [CFG_W-1:0] thr, margin, debounce, click_lim, long_lim, hold_lim;

  logic              pad_down [NUM_CHANNELS];
  logic              pad_hold [NUM_CHANNELS];
  logic              pad_click[NUM_CHANNELS];
  logic              pad_long [NUM_CHANNELS];
  logic [TIME_W-1:0] edge_t   [NUM_CHANNELS];
  logic [TIME_W-1:0] press_t  [NUM_CHANNELS];
  logic [TIME_W-1:0] click_t  [NUM_CHANNELS];
  logic [TIME_W-1:0] long_t   [NUM_CHANNELS];

  tgc_out_t status_due[$];
  int       results_seen;

  initial begin
    errors_o    = 0;
    in_flight_o = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, want %0d (result %0d)", what, got, want, results_seen);
    errors_o++;
  endtask

  // status of the pad after a sample, or before a read clears its events
  function automatic tgc_out_t predict_status(tgc_in_t it);
    tgc_out_t          st;
    int unsigned       c;
    logic [TIME_W-1:0] since;
    logic [16:0]       low_sum;
    st = '0;
    st.out_channel = it.channel;
    if (it.channel >= NUM_CHANNELS) return st;
    c = 32'(it.channel);
    if (item_kind_e'(it.kind) == KIND_SAMPLE) begin
      since = it.now_ms - edge_t[c];
      if (since > debounce) begin
        low_sum = {1'b0, it.sample} + {1'b0, margin};
        if (it.sample > thr && !pad_down[c]) begin
          pad_down[c] = 1'b1;
          edge_t[c]   = it.now_ms;
          press_t[c]  = it.now_ms;
        end else if (low_sum < {1'b0, thr} && pad_down[c]) begin
          pad_down[c] = 1'b0;
          edge_t[c]   = it.now_ms;
          pad_hold[c] = 1'b0;
          if (since < click_lim) begin
            pad_click[c] = 1'b1;
            click_t[c]   = it.now_ms;
          end else if (since < long_lim) begin
            pad_long[c] = 1'b1;
            long_t[c]   = it.now_ms;
          end
        end
        if (pad_click[c] && (it.now_ms - click_t[c]) > click_lim) pad_click[c] = 1'b0;
        if (pad_long[c] && (it.now_ms - long_t[c]) > long_lim) pad_long[c] = 1'b0;
        if (pad_down[c] && (it.now_ms - press_t[c]) > hold_lim) pad_hold[c] = 1'b1;
      end
    end
    st.touched      = pad_down[c];
    st.held         = pad_hold[c];
    st.clicked      = pad_click[c];
    st.long_clicked = pad_long[c];
    if (item_kind_e'(it.kind) == KIND_READ) begin
      pad_click[c] = 1'b0;
      pad_long[c]  = 1'b0;
    end
    return st;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tgc_out_t want;
    if (!rst_ni) begin
      thr       = RST_TOUCH_THRESHOLD;
      margin    = RST_RELEASE_MARGIN;
      debounce  = RST_DEBOUNCE_MS;
      click_lim = RST_CLICK_LIMIT_MS;
      long_lim  = RST_LONG_LIMIT_MS;
      hold_lim  = RST_HOLD_MS;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        pad_down[c]  = 1'b0;
        pad_hold[c]  = 1'b0;
        pad_click[c] = 1'b0;
        pad_long[c]  = 1'b0;
        edge_t[c]    = '0;
        press_t[c]   = '0;
        click_t[c]   = '0;
        long_t[c]    = '0;
      end
      status_due.delete();
      in_flight_o  = 0;
      results_seen = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TOUCH_THRESHOLD: thr       = cfg_wdata_i;
          CFG_RELEASE_MARGIN:  margin    = cfg_wdata_i;
          CFG_DEBOUNCE_MS:     debounce  = cfg_wdata_i;
          CFG_CLICK_LIMIT_MS:  click_lim = cfg_wdata_i;
          CFG_LONG_LIMIT_MS:   long_lim  = cfg_wdata_i;
          CFG_HOLD_MS:         hold_lim  = cfg_wdata_i;
          default: ;
        endcase
      end
      // results leave first; they always belong to older transfers
      if (out_valid_i && out_ready_i) begin
        if (status_due.size() == 0) begin
          report_mismatch("unexpected result", int'(out_data_i), 0);
        end else begin
          want = status_due.pop_front();
          if (out_data_i.out_channel !== want.out_channel)
            report_mismatch("out_channel", int'(out_data_i.out_channel),
                            int'(want.out_channel));
          if (out_data_i.touched !== want.touched)
            report_mismatch("touched", int'(out_data_i.touched), int'(want.touched));
          if (out_data_i.held !== want.held)
            report_mismatch("held", int'(out_data_i.held), int'(want.held));
          if (out_data_i.clicked !== want.clicked)
            report_mismatch("clicked", int'(out_data_i.clicked), int'(want.clicked));
          if (out_data_i.long_clicked !== want.long_clicked)
            report_mismatch("long_clicked", int'(out_data_i.long_clicked),
                            int'(want.long_clicked));
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_i) status_due.push_back(predict_status(in_data_i));
      in_flight_o = status_due.size();
    end
  end

endmodule

// ===== tb/tb_touch_gesture_classifier.sv =====
module tb_touch_gesture_classifier;
  import tgc_pkg::*;

  // generous cap: every item waiting out the longest send gap and receive stall
  localparam int LIMIT_CYCLES = 1_000_000;
  // idle tail after every status has come back
  localparam int TAIL_CYCLES  = 4;
  localparam int PHASE_ITEMS  = 240;

  logic        clk_i     = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  tgc_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  tgc_out_t    out_data;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_idx   = '0;
  logic [15:0] cfg_wdata = '0;

  int errors;
  int in_flight;
  int cycles     = 0;
  int items_sent = 0;

  // when set, neither side inserts gaps
  bit steady = 1'b0;

  // stimulus-side copy of the register settings, used only to aim the values
  logic [15:0] thr_set   = RST_TOUCH_THRESHOLD;
  logic [15:0] mg_set    = RST_RELEASE_MARGIN;
  logic [15:0] db_set    = RST_DEBOUNCE_MS;
  logic [15:0] click_set = RST_CLICK_LIMIT_MS;
  logic [15:0] long_set  = RST_LONG_LIMIT_MS;
  logic [15:0] hold_set  = RST_HOLD_MS;

  // shared time base for the well-formed gestures
  logic [31:0] t_now;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  touch_gesture_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  tgc_checker scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (errors),
    .in_flight_o (in_flight)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver: ready high for a while, then a random stall
  initial begin
    int n;
    forever begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        @(negedge clk_i);
        out_ready <= 1'b1;
      end
      n = gap_len();
      repeat (n) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
      end
    end
  end

  // one transfer on the input channel, after an optional gap
  task automatic send_item(input item_kind_e kind, input logic [2:0] ch,
                           input logic [31:0] now, input logic [15:0] smp);
    tgc_in_t it;
    int      idle;
    it.kind    = kind;
    it.channel = ch;
    it.now_ms  = now;
    it.sample  = smp;
    idle = gap_len();
    repeat (idle) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
  endtask

  // stop sending and wait until every status has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
  endtask

  task automatic set_regs(input logic [15:0] thr, input logic [15:0] mg,
                          input logic [15:0] db, input logic [15:0] cl,
                          input logic [15:0] ll, input logic [15:0] hd);
    write_reg(CFG_TOUCH_THRESHOLD, thr);
    write_reg(CFG_RELEASE_MARGIN, mg);
    write_reg(CFG_DEBOUNCE_MS, db);
    write_reg(CFG_CLICK_LIMIT_MS, cl);
    write_reg(CFG_LONG_LIMIT_MS, ll);
    write_reg(CFG_HOLD_MS, hd);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    thr_set   = thr;
    mg_set    = mg;
    db_set    = db;
    click_set = cl;
    long_set  = ll;
    hold_set  = hd;
  endtask

  // samples strictly below this level release a touched pad; zero means never
  function automatic int rel_floor();
    return (thr_set > mg_set) ? int'(thr_set) - int'(mg_set) : 0;
  endfunction

  function automatic logic [15:0] press_level();
    if (thr_set == 16'hFFFF) return 16'hFFFF;
    case ($urandom_range(0, 3))
      0: return thr_set + 16'd1;
      1: return 16'hFFFF;
      2: return thr_set;  // at the threshold, not above: no press
      default: return 16'($urandom_range(32'(thr_set) + 1, 32'hFFFF));
    endcase
  endfunction

  function automatic logic [15:0] release_level();
    int fl;
    fl = rel_floor();
    if (fl == 0) return 16'($urandom);
    case ($urandom_range(0, 4))
      0: return 16'(fl - 1);
      1: return 16'd0;
      2: return 16'(fl);  // right on the release level: stays touched
      default: return 16'($urandom_range(0, fl - 1));
    endcase
  endfunction

  // at or above the release level, so a touched pad stays touched
  function automatic logic [15:0] hover_level();
    if ($urandom_range(0, 3) == 0) return thr_set;
    return 16'($urandom_range(rel_floor(), 32'hFFFF));
  endfunction

  // time spans aimed at the edges of the configured windows
  function automatic logic [31:0] span();
    case ($urandom_range(0, 11))
      0:  return 32'(db_set);
      1:  return 32'(db_set) + 1;
      2:  return 32'(click_set) - 1;
      3:  return 32'(click_set);
      4:  return 32'(click_set) + 1;
      5:  return 32'(long_set) - 1;
      6:  return 32'(long_set);
      7:  return 32'(long_set) + 1;
      8:  return 32'(hold_set);
      9:  return 32'(hold_set) + 1;
      10: return $urandom_range(0, 20);
      default: return $urandom_range(0, 200000);
    endcase
  endfunction

  function automatic logic [31:0] lead_gap();
    if ($urandom_range(0, 4) != 0) return 32'(db_set) + 1 + $urandom_range(0, 30);
    return span();
  endfunction

  // press, a few samples while held, release, and often a read right after
  task automatic gesture(input logic [2:0] ch);
    logic [31:0] t_press;
    int          hovers;
    t_now   = t_now + lead_gap();
    t_press = t_now;
    send_item(KIND_SAMPLE, ch, t_press, press_level());
    hovers = $urandom_range(0, 3);
    repeat (hovers) send_item(KIND_SAMPLE, ch, t_press + span(), hover_level());
    t_now = t_press + span();
    send_item(KIND_SAMPLE, ch, t_now, release_level());
    if ($urandom_range(0, 9) < 6) begin
      if ($urandom_range(0, 1) == 0)
        send_item(KIND_READ, ch, t_now + $urandom_range(0, 40), 16'($urandom));
      else
        send_item(KIND_READ, ch, t_now + span(), 16'($urandom));
    end
  endtask

  task automatic random_items(input int count);
    int target;
    int r;
    int mark;
    target = items_sent + count;
    mark   = items_sent;
    t_now  = $urandom;
    while (items_sent < target) begin
      // switch between gapped and gap-free stretches
      if (items_sent - mark >= 64) begin
        steady = ($urandom_range(0, 3) == 0);
        mark   = items_sent;
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        gesture(3'($urandom_range(0, NUM_CHANNELS - 1)));
      end else if (r < 85) begin
        send_item(KIND_READ, 3'($urandom_range(0, 7)), t_now + $urandom_range(0, 50),
                  16'($urandom));
      end else begin
        // noise: anything the fields allow, including pads that do not exist
        send_item(item_kind_e'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  ($urandom_range(0, 1) == 0) ? $urandom : t_now + $urandom_range(0, 100),
                  16'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // directed part, register defaults
    send_item(KIND_READ,   3'd0, 32'd0,   16'd0);      // fresh pad reads all clear
    send_item(KIND_SAMPLE, 3'd0, 32'd0,   16'd301);    // inside debounce window
    send_item(KIND_SAMPLE, 3'd0, 32'd51,  16'd300);    // at threshold, no press
    send_item(KIND_SAMPLE, 3'd0, 32'd51,  16'd301);    // press
    send_item(KIND_SAMPLE, 3'd0, 32'd101, 16'd0);      // debounced away
    send_item(KIND_SAMPLE, 3'd0, 32'd102, 16'd199);    // release, short touch: click
    send_item(KIND_READ,   3'd0, 32'd103, 16'hFFFF);   // reports click, clears it
    send_item(KIND_READ,   3'd0, 32'd104, 16'd0);      // cleared
    send_item(KIND_SAMPLE, 3'd1, 32'd1000, 16'hFFFF);  // press
    send_item(KIND_SAMPLE, 3'd1, 32'd2500, 16'd0);     // touch at click limit: long click
    send_item(KIND_READ,   3'd1, 32'd2501, 16'd0);
    send_item(KIND_SAMPLE, 3'd2, 32'd5000, 16'd301);   // press
    send_item(KIND_SAMPLE, 3'd2, 32'd8001, 16'd250);   // hovering past hold time
    send_item(KIND_SAMPLE, 3'd2, 32'd9000, 16'd0);     // too long for any event
    send_item(KIND_SAMPLE, 3'd3, 32'd10000, 16'd500);
    send_item(KIND_SAMPLE, 3'd3, 32'd10100, 16'd0);    // click
    send_item(KIND_SAMPLE, 3'd3, 32'd11601, 16'd250);  // click expires
    send_item(KIND_SAMPLE, 3'd4, 32'hFFFF_FFF0, 16'd400);  // press right before wrap
    send_item(KIND_SAMPLE, 3'd4, 32'h0000_0010, 16'd0);    // wrapped, still debounced
    send_item(KIND_SAMPLE, 3'd4, 32'h0000_0100, 16'd0);    // click across the wrap
    send_item(KIND_READ,   3'd4, 32'h0000_0101, 16'd0);
    send_item(KIND_SAMPLE, 3'd5, 32'd20000, 16'hFFFF);     // pads out of range
    send_item(KIND_READ,   3'd6, 32'd20001, 16'd0);
    send_item(KIND_READ,   3'd7, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(KIND_SAMPLE, 3'd7, 32'h8000_0000, 16'h8000);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: ;  // stay on the defaults
        1: set_regs(16'd1000, 16'd20, 16'd3, 16'd20, 16'd50, 16'd40);
        2: set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        3: set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        4: set_regs(16'd200, 16'd500, 16'd10, 16'd100, 16'd300, 16'd200);  // margin too big
        6: set_regs(16'h5555, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        7: set_regs(16'hFFFE, 16'hAAAA, 16'd1, 16'd3000, 16'd1000, 16'd10);
        default: set_regs(16'($urandom), 16'($urandom), 16'($urandom_range(0, 200)),
                          16'($urandom_range(0, 4000)), 16'($urandom_range(0, 8000)),
                          16'($urandom_range(0, 6000)));
      endcase
      random_items(PHASE_ITEMS);
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tgc_pkg.sv
hdl/tgc_cfg_regs.sv
hdl/tgc_update.sv
hdl/touch_gesture_classifier.sv
tb/tgc_checker.sv
tb/tb_touch_gesture_classifier.sv
